// ----- rtl/etmc_pkg.sv -----
package etmc_pkg;

    // Fixed-point format of all external values
    localparam int FRAC_BITS = 16;

    // Angle reduction widths and constants; FULL, HALF and QUARTER are in degrees with FRAC_BITS fraction
    localparam int  R_W       = FRAC_BITS + 9;
    localparam int  M_W       = FRAC_BITS + 7;
    localparam int  P_W       = M_W + 32;
    localparam longint FULL    = 64'sd45 << (FRAC_BITS + 3);
    localparam longint HALF    = 64'sd45 << (FRAC_BITS + 2);
    localparam longint QUARTER = 64'sd45 << (FRAC_BITS + 1);
    localparam longint RND_DIV = 64'sd45 << (FRAC_BITS + 1);
    localparam longint WRAP_C0 = (64'sd1 << 31) % FULL;

    // Q2.30 constants
    localparam logic [31:0] PI_Q30       = 32'hC90F_DAA2;
    localparam logic signed [31:0] K_Q30 = 32'sh26DD_3B6A;

    localparam int CORDIC_STEPS = 24;
    localparam logic signed [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
        32'sh3243F6A8, 32'sh1DAC6705, 32'sh0FADBAFC, 32'sh07F56EA6,
        32'sh03FEAB76, 32'sh01FFD55B, 32'sh00FFFAAA, 32'sh007FFF55,
        32'sh003FFFEA, 32'sh001FFFFD, 32'sh000FFFFF, 32'sh0007FFFF,
        32'sh0003FFFF, 32'sh0001FFFF, 32'sh0000FFFF, 32'sh00007FFF,
        32'sh00003FFF, 32'sh00001FFF, 32'sh00000FFF, 32'sh000007FF,
        32'sh000003FF, 32'sh000001FF, 32'sh000000FF, 32'sh0000007F
    };

    // Pipeline depths
    localparam int SC_LAT = 6 + CORDIC_STEPS + 1;
    localparam int LAT    = SC_LAT + 5;
    localparam int D_LEN  = LAT - 1;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] angle_x;
        logic signed [31:0] angle_y;
        logic signed [31:0] angle_z;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] row0_col0;
        logic signed [31:0] row0_col1;
        logic signed [31:0] row0_col2;
        logic signed [31:0] row1_col0;
        logic signed [31:0] row1_col1;
        logic signed [31:0] row1_col2;
        logic signed [31:0] row2_col0;
        logic signed [31:0] row2_col1;
        logic signed [31:0] row2_col2;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
    } result_t;

    // floor(v / 45) for v < 45 * 2^16 by reciprocal multiply (exact in range)
    localparam logic [23:0] RECIP45 = 24'((64'd1 << 29) / 45 + 1);

    function automatic logic [15:0] div45(input logic [21:0] v);
        logic [45:0] p;
        p = 46'(v) * 46'(RECIP45);
        return p[44:29];
    endfunction

    // Q2.30 product, rounded half up
    function automatic logic signed [31:0] mulq30(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + (64'sd1 <<< 29);
        return p[61:30];
    endfunction

endpackage

// ----- rtl/etmc_sincos.sv -----
module etmc_sincos (
    input  logic               clk,
    input  logic signed [31:0] angle,
    output logic signed [31:0] sin_q30,
    output logic signed [31:0] cos_q30
);
    import etmc_pkg::*;

    // stage 1: fold the angle into [0, 360) after a 2^31 offset
    logic [31:0]   u;
    logic [21:0]   hi_ext;
    logic [15:0]   hi_q;
    logic [21:0]   hi_prod;
    logic [5:0]    hi_rem;
    logic [R_W-1:0] r1_reg, r1_next;

    assign u       = {~angle[31], angle[30:0]};
    assign hi_ext  = 22'(u[31:FRAC_BITS+3]);
    assign hi_q    = div45(hi_ext);
    assign hi_prod = 22'(hi_q) * 22'd45;
    assign hi_rem  = 6'(hi_ext - hi_prod);
    assign r1_next = {hi_rem, u[FRAC_BITS+2:0]};

    // stage 2: remove offset, map to [-90, 90], take magnitude
    logic signed [R_W+1:0] r2, rs, ra;
    logic                  flip2, neg2;
    logic [M_W-1:0]        mag_next, mag_reg;
    logic                  flip_s2_reg, neg_s2_reg;

    always_comb
    begin
        if ({2'b00, r1_reg} >= (R_W+2)'(WRAP_C0))
            r2 = $signed({2'b00, r1_reg}) - (R_W+2)'(WRAP_C0);
        else
            r2 = $signed({2'b00, r1_reg}) + (R_W+2)'(FULL - WRAP_C0);
        rs = (r2 > (R_W+2)'(HALF)) ? r2 - (R_W+2)'(FULL) : r2;
        flip2 = 1'b0;
        ra = rs;
        if (rs > (R_W+2)'(QUARTER))
        begin
            ra = rs - (R_W+2)'(HALF);
            flip2 = 1'b1;
        end
        else if (rs < -(R_W+2)'(QUARTER))
        begin
            ra = rs + (R_W+2)'(HALF);
            flip2 = 1'b1;
        end
        neg2 = ra[R_W+1];
        mag_next = neg2 ? M_W'(-ra) : M_W'(ra);
    end

    // stage 3: degrees times pi
    logic [P_W-1:0] prod_reg, prod_next;
    logic           flip_s3_reg, neg_s3_reg;

    assign prod_next = P_W'(mag_reg) * P_W'(PI_Q30);

    // stage 4: divide by 2^(F+2), rounded for the whole divide by 45 * 2^(F+2), high digit of divide by 45
    logic [P_W:0]  t_sum;
    logic [36:0]   t_val;
    logic [36:0]   t_reg;
    logic [15:0]   q1_next, q1_s4_reg;
    logic          flip_s4_reg, neg_s4_reg;

    assign t_sum   = (P_W+1)'(prod_reg) + (P_W+1)'(RND_DIV);
    assign t_val   = 37'(t_sum >> (FRAC_BITS + 2));
    assign q1_next = div45({1'b0, t_val[36:16]});

    // stage 5: remainder of the high digit joins the low bits
    logic [21:0]   r5_prod;
    logic [5:0]    r5_rem;
    logic [21:0]   v2_reg;
    logic [15:0]   q1_s5_reg;
    logic          flip_s5_reg, neg_s5_reg;

    assign r5_prod = 22'(q1_s4_reg) * 22'd45;
    assign r5_rem  = 6'({1'b0, t_reg[36:16]} - r5_prod);

    // stage 6: low digit, signed radians
    logic [31:0]        zu;
    logic signed [31:0] z6_next;

    assign zu      = {q1_s5_reg, div45(v2_reg)};
    assign z6_next = neg_s5_reg ? -$signed(zu) : $signed(zu);

    // front-end registers
    always_ff @(posedge clk)
    begin
        r1_reg      <= r1_next;
        mag_reg     <= mag_next;
        flip_s2_reg <= flip2;
        neg_s2_reg  <= neg2;
        prod_reg    <= prod_next;
        flip_s3_reg <= flip_s2_reg;
        neg_s3_reg  <= neg_s2_reg;
        t_reg       <= t_val;
        q1_s4_reg   <= q1_next;
        flip_s4_reg <= flip_s3_reg;
        neg_s4_reg  <= neg_s3_reg;
        v2_reg      <= {r5_rem, t_reg[15:0]};
        q1_s5_reg   <= q1_s4_reg;
        flip_s5_reg <= flip_s4_reg;
        neg_s5_reg  <= neg_s4_reg;
    end

    // CORDIC rotation, one micro-rotation per stage
    logic signed [31:0] x_reg [0:CORDIC_STEPS];
    logic signed [31:0] y_reg [0:CORDIC_STEPS];
    logic signed [31:0] z_reg [0:CORDIC_STEPS];
    logic               f_reg [0:CORDIC_STEPS];

    always_ff @(posedge clk)
    begin
        x_reg[0] <= K_Q30;
        y_reg[0] <= '0;
        z_reg[0] <= z6_next;
        f_reg[0] <= flip_s5_reg;
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_rot
        logic signed [31:0] dx, dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        always_ff @(posedge clk)
        begin
            if (!z_reg[i][31])
            begin
                x_reg[i+1] <= x_reg[i] - dx;
                y_reg[i+1] <= y_reg[i] + dy;
                z_reg[i+1] <= z_reg[i] - ATAN_Q30[i];
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + dx;
                y_reg[i+1] <= y_reg[i] - dy;
                z_reg[i+1] <= z_reg[i] + ATAN_Q30[i];
            end
            f_reg[i+1] <= f_reg[i];
        end
    end

    // quadrant fix-up
    logic signed [31:0] sin_reg, cos_reg;
    logic               z_unused;

    assign z_unused = z_reg[CORDIC_STEPS][0];

    always_ff @(posedge clk)
    begin
        sin_reg <= f_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];
        cos_reg <= f_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
    end

    assign sin_q30 = z_unused ? sin_reg : sin_reg;
    assign cos_q30 = cos_reg;

endmodule

// ----- rtl/euler_trs_matrix_compose.sv -----
// Throughput: one beat per cycle; busy is never raised.
// The depth is set per angle by six reduction stages, the 24-stage CORDIC and
// its sign fix-up, then five matrix stages (two multiply/round, sum, scale, round).
// The receiver cannot stall: each result is shown for one cycle.
// Reset (rst_n low, async) clears the valid pipeline only.
module euler_trs_matrix_compose (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  etmc_pkg::cmd_t   cmd,
    output logic             done,
    output etmc_pkg::result_t result
);
    import etmc_pkg::*;

    // valid bits and payload delay line
    logic [LAT-1:0] vld_reg;
    cmd_t           dly_reg [0:D_LEN-1];

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], start & ~busy};
    end

    always_ff @(posedge clk)
    begin
        dly_reg[0] <= cmd;
        for (int k = 1; k < D_LEN; k++)
            dly_reg[k] <= dly_reg[k-1];
    end

    // sine and cosine per axis
    logic signed [31:0] sx, cx, sy, cy, sz, cz;

    etmc_sincos u_sc_x (.clk(clk), .angle(cmd.angle_x), .sin_q30(sx), .cos_q30(cx));
    etmc_sincos u_sc_y (.clk(clk), .angle(cmd.angle_y), .sin_q30(sy), .cos_q30(cy));
    etmc_sincos u_sc_z (.clk(clk), .angle(cmd.angle_z), .sin_q30(sz), .cos_q30(cz));

    // stage A: pairwise products
    logic signed [31:0] cycz_reg, cysz_reg, sxsy_reg, cxsz_reg, cxcz_reg;
    logic signed [31:0] sxcy_reg, sxsz_reg, cxsy_reg, sxcz_reg, cxcy_reg;
    logic signed [31:0] sya_reg, cza_reg, sza_reg;

    always_ff @(posedge clk)
    begin
        cycz_reg <= mulq30(cy, cz);
        cysz_reg <= mulq30(cy, sz);
        sxsy_reg <= mulq30(sx, sy);
        cxsz_reg <= mulq30(cx, sz);
        cxcz_reg <= mulq30(cx, cz);
        sxcy_reg <= mulq30(sx, cy);
        sxsz_reg <= mulq30(sx, sz);
        cxsy_reg <= mulq30(cx, sy);
        sxcz_reg <= mulq30(sx, cz);
        cxcy_reg <= mulq30(cx, cy);
        sya_reg  <= sy;
        cza_reg  <= cz;
        sza_reg  <= sz;
    end

    // stage B: triple products, pass the rest
    logic signed [31:0] sxsycz_reg, sxsysz_reg, cxsycz_reg, cxsysz_reg;
    logic signed [31:0] b_cycz_reg, b_cysz_reg, b_sy_reg, b_cxsz_reg, b_cxcz_reg;
    logic signed [31:0] b_sxcy_reg, b_sxsz_reg, b_sxcz_reg, b_cxcy_reg;

    always_ff @(posedge clk)
    begin
        sxsycz_reg <= mulq30(sxsy_reg, cza_reg);
        sxsysz_reg <= mulq30(sxsy_reg, sza_reg);
        cxsycz_reg <= mulq30(cxsy_reg, cza_reg);
        cxsysz_reg <= mulq30(cxsy_reg, sza_reg);
        b_cycz_reg <= cycz_reg;
        b_cysz_reg <= cysz_reg;
        b_sy_reg   <= sya_reg;
        b_cxsz_reg <= cxsz_reg;
        b_cxcz_reg <= cxcz_reg;
        b_sxcy_reg <= sxcy_reg;
        b_sxsz_reg <= sxsz_reg;
        b_sxcz_reg <= sxcz_reg;
        b_cxcy_reg <= cxcy_reg;
    end

    // stage C: rotation entries
    logic signed [32:0] m_reg [9];

    always_ff @(posedge clk)
    begin
        m_reg[0] <= 33'(b_cycz_reg);
        m_reg[1] <= -33'(b_cysz_reg);
        m_reg[2] <= 33'(b_sy_reg);
        m_reg[3] <= 33'(sxsycz_reg) + 33'(b_cxsz_reg);
        m_reg[4] <= 33'(b_cxcz_reg) - 33'(sxsysz_reg);
        m_reg[5] <= -33'(b_sxcy_reg);
        m_reg[6] <= 33'(b_sxsz_reg) - 33'(cxsycz_reg);
        m_reg[7] <= 33'(cxsysz_reg) + 33'(b_sxcz_reg);
        m_reg[8] <= 33'(b_cxcy_reg);
    end

    // stage D: scale each column
    logic signed [31:0] sc [3];
    logic signed [64:0] ps_reg [9];

    assign sc[0] = dly_reg[D_LEN-2].scale_x;
    assign sc[1] = dly_reg[D_LEN-2].scale_y;
    assign sc[2] = dly_reg[D_LEN-2].scale_z;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
            ps_reg[k] <= 65'(m_reg[k]) * 65'(sc[k % 3]);
    end

    // stage E: round, saturate, output register
    logic signed [31:0] ent [9];

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            logic signed [64:0] rs;
            logic signed [34:0] v;
            rs = ps_reg[k] + (65'sd1 <<< 29);
            v  = rs[64:30];
            if (v > 35'sd2147483647)
                ent[k] = 32'sh7FFF_FFFF;
            else if (v < -35'sd2147483648)
                ent[k] = 32'sh8000_0000;
            else
                ent[k] = v[31:0];
        end
    end

    result_t res_reg;

    always_ff @(posedge clk)
    begin
        res_reg.row0_col0 <= ent[0];
        res_reg.row0_col1 <= ent[1];
        res_reg.row0_col2 <= ent[2];
        res_reg.row1_col0 <= ent[3];
        res_reg.row1_col1 <= ent[4];
        res_reg.row1_col2 <= ent[5];
        res_reg.row2_col0 <= ent[6];
        res_reg.row2_col1 <= ent[7];
        res_reg.row2_col2 <= ent[8];
        res_reg.offset_x  <= dly_reg[D_LEN-1].pos_x;
        res_reg.offset_y  <= dly_reg[D_LEN-1].pos_y;
        res_reg.offset_z  <= dly_reg[D_LEN-1].pos_z;
    end

    assign result = res_reg;
    assign done   = vld_reg[LAT-1];

    // checks
    a_done_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without matching command");

    a_cmd_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("command lost in pipeline");

    a_offset_pass: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.offset_x == $past(cmd.pos_x, LAT)))
        else $error("translation misaligned with its beat");

endmodule
